>>> hdl/indexed_heap_priority_queue_top_macros.svh
// assertion macros shared by the heap queue modules
`ifndef INDEXED_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define INDEXED_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH

// property must hold at every clock edge outside reset
`define IHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true outside reset
`define IHPQ_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

>>> hdl/ihpq_pkg.sv
// package for the indexed heap queue: constants, codes and control structs
package ihpq_pkg;

  localparam int DEF_CAPACITY = 256;
  localparam int DEF_KEY_BITS = 32;
  localparam int HANDLE_W     = 8;
  localparam int NUM_HANDLES  = 256;
  localparam int OCC_W        = 9;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_REKEY  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_DUP     = 3'd4
  } status_e;

  // slot memory read address select
  typedef enum logic [2:0] {
    RA_I      = 3'd0,
    RA_LAST   = 3'd1,
    RA_PARENT = 3'd2,
    RA_LEFT   = 3'd3,
    RA_RIGHT  = 3'd4
  } rd_sel_e;

  typedef struct packed {
    logic    latch_in;
    logic    ld_ins;
    logic    ld_pop;
    logic    ld_pos;
    logic    ld_rekey;
    logic    take_first;
    logic    ld_last;
    logic    dec_cnt;
    logic    up_move;
    logic    dn_left;
    logic    dn_move;
    logic    dn_right;
    logic    fin_write;
    logic    done;
    rd_sel_e rd_sel;
    status_e res;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic present;
    logic pos_bad;
    logic i_zero;
    logic i_last;
    logic left_in;
    logic right_in;
    logic rd_prec_mv;
    logic right_best;
    logic best_left;
    logic moved;
  } sts_t;

endpackage

>>> hdl/indexed_heap_priority_queue_top.sv
// Indexed binary min/max heap priority queue, top level.
//
// A command beat is taken when start is high while busy is low: op_i selects
// insert (key_i, handle_i), pop of the top entry, remove by handle_i, or rekey
// of handle_i to key_i. Exactly one result follows per command: done_o is high
// for one cycle with out_key_o/out_handle_o (the removed entry, else zero),
// status_o and occupancy_o. The receiver cannot stall; done_o is never held.
// busy stays high from the accepted beat until the result cycle, so the next
// command can be issued in the cycle done_o is seen.
// Insert errors and unknown handles end without touching the heap. An insert
// climbs from the last slot; pop and remove take the entry out, end there if
// it sat in the last slot, else move the last entry into the hole; remove and
// rekey first look up the handle's slot. The moved entry then checks its
// parent and climbs, or sinks when it did not climb.
// Every sift step is bound by the single read port of the slot memory and
// its registered read.
// cfg_we_i writes cfg_data_i into the order bit (1 serves largest first);
// write it only while idle. Reset empties the queue and selects smallest first.
module indexed_heap_priority_queue_top import ihpq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     op_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [HANDLE_W-1:0] handle_i,
  output logic                done_o,
  output logic [KEY_BITS-1:0] out_key_o,
  output logic [HANDLE_W-1:0] out_handle_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [OCC_W-1:0]    occupancy_o
);

  cmd_t cmd;
  sts_t sts;

  ihpq_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .op_i  (op_i),
    .sts_i (sts),
    .busy  (busy),
    .cmd_o (cmd)
  );

  ihpq_datapath #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .key_i       (key_i),
    .handle_i    (handle_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .out_key_o   (out_key_o),
    .out_handle_o(out_handle_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

endmodule

>>> hdl/ihpq_ram.sv
// generic single-write, single-read ram with registered read data
module ihpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/ihpq_datapath.sv
// heap datapath: slot and position memories, presence bits, sift registers
`include "indexed_heap_priority_queue_top_macros.svh"
module ihpq_datapath import ihpq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                done_o,
  output logic [KEY_BITS-1:0] out_key_o,
  output logic [HANDLE_W-1:0] out_handle_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [OCC_W-1:0]    occupancy_o
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int EXT_W  = CNT_W + 1;
  localparam int ENT_W  = KEY_BITS + HANDLE_W;

  logic                   max_first_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [HANDLE_W-1:0]    h_q;
  logic [SLOT_W-1:0]      i_q, i_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [KEY_BITS-1:0]    mv_key_q, mv_key_d;
  logic [HANDLE_W-1:0]    mv_h_q, mv_h_d;
  logic [KEY_BITS-1:0]    cand_key_q;
  logic [HANDLE_W-1:0]    cand_h_q;
  logic                   best_left_q;
  logic                   moved_q, moved_d;
  logic [KEY_BITS-1:0]    rk_q, rk_d;
  logic [HANDLE_W-1:0]    rh_q, rh_d;
  logic [NUM_HANDLES-1:0] present_q, present_d;

  logic [ENT_W-1:0]    slot_rdata, slot_wdata;
  logic [SLOT_W-1:0]   slot_raddr;
  logic                slot_we;
  logic [SLOT_W-1:0]   pos_rdata;
  logic [KEY_BITS-1:0] rd_key, best_key;
  logic [HANDLE_W-1:0] rd_h;
  logic [EXT_W-1:0]    left_x, right_x;
  logic [SLOT_W-1:0]   parent_idx, last_idx;
  logic [CNT_W-1:0]    i_ext, cnt_m1;

  function automatic logic prec(input logic mf, input logic [KEY_BITS-1:0] a,
                                input logic [KEY_BITS-1:0] b);
    prec = mf ? (a > b) : (a < b);
  endfunction

  assign rd_key     = slot_rdata[ENT_W-1:HANDLE_W];
  assign rd_h       = slot_rdata[HANDLE_W-1:0];
  assign i_ext      = CNT_W'(i_q);
  assign cnt_m1     = cnt_q - CNT_W'(1);
  assign left_x     = (EXT_W'(i_q) << 1) + EXT_W'(1);
  assign right_x    = (EXT_W'(i_q) << 1) + EXT_W'(2);
  assign parent_idx = (i_q - SLOT_W'(1)) >> 1;
  assign last_idx   = cnt_m1[SLOT_W-1:0];
  assign best_key   = best_left_q ? cand_key_q : mv_key_q;

  always_comb begin
    case (cmd_i.rd_sel)
      RA_I:      slot_raddr = i_q;
      RA_LAST:   slot_raddr = last_idx;
      RA_PARENT: slot_raddr = parent_idx;
      RA_LEFT:   slot_raddr = left_x[SLOT_W-1:0];
      RA_RIGHT:  slot_raddr = right_x[SLOT_W-1:0];
      default:   slot_raddr = i_q;
    endcase
  end

  // the entry written at the hole: parent moving down, child moving up, or the mover itself
  always_comb begin
    slot_we = cmd_i.up_move | cmd_i.dn_move | cmd_i.fin_write;
    if (cmd_i.up_move || (cmd_i.dn_move && cmd_i.dn_right)) begin
      slot_wdata = slot_rdata;
    end else if (cmd_i.dn_move) begin
      slot_wdata = {cand_key_q, cand_h_q};
    end else begin
      slot_wdata = {mv_key_q, mv_h_q};
    end
  end

  ihpq_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(i_q),
    .wdata_i(slot_wdata),
    .raddr_i(slot_raddr),
    .rdata_o(slot_rdata)
  );

  ihpq_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_HANDLES)) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_wdata[HANDLE_W-1:0]),
    .wdata_i(i_q),
    .raddr_i(h_q),
    .rdata_o(pos_rdata)
  );

  always_comb begin
    i_d       = i_q;
    cnt_d     = cnt_q;
    mv_key_d  = mv_key_q;
    mv_h_d    = mv_h_q;
    moved_d   = moved_q;
    rk_d      = rk_q;
    rh_d      = rh_q;
    present_d = present_q;
    if (cmd_i.latch_in) begin
      moved_d = 1'b0;
      rk_d    = '0;
      rh_d    = '0;
    end
    if (cmd_i.ld_ins) begin
      i_d            = cnt_q[SLOT_W-1:0];
      cnt_d          = cnt_q + CNT_W'(1);
      present_d[h_q] = 1'b1;
    end
    if (cmd_i.ld_ins || cmd_i.ld_rekey) begin
      mv_key_d = key_q;
      mv_h_d   = h_q;
    end
    if (cmd_i.ld_pop) begin
      i_d = '0;
    end
    if (cmd_i.ld_pos) begin
      i_d = pos_rdata;
    end
    if (cmd_i.take_first) begin
      rk_d            = rd_key;
      rh_d            = rd_h;
      present_d[rd_h] = 1'b0;
    end
    if (cmd_i.ld_last) begin
      mv_key_d = rd_key;
      mv_h_d   = rd_h;
    end
    if (cmd_i.dec_cnt) begin
      cnt_d = cnt_m1;
    end
    if (cmd_i.up_move) begin
      i_d     = parent_idx;
      moved_d = 1'b1;
    end
    if (cmd_i.dn_move) begin
      i_d = cmd_i.dn_right ? right_x[SLOT_W-1:0] : left_x[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_first_q <= 1'b0;
      cnt_q       <= '0;
      present_q   <= '0;
      done_o      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_first_q <= cfg_data_i;
      end
      cnt_q     <= cnt_d;
      present_q <= present_d;
      done_o    <= cmd_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      key_q <= key_i;
      h_q   <= handle_i;
    end
    if (cmd_i.dn_left) begin
      cand_key_q  <= rd_key;
      cand_h_q    <= rd_h;
      best_left_q <= prec(max_first_q, rd_key, mv_key_q);
    end
    i_q      <= i_d;
    mv_key_q <= mv_key_d;
    mv_h_q   <= mv_h_d;
    moved_q  <= moved_d;
    rk_q     <= rk_d;
    rh_q     <= rh_d;
    if (cmd_i.done) begin
      out_key_o    <= rk_d;
      out_handle_o <= rh_d;
      status_o     <= cmd_i.res;
      occupancy_o  <= OCC_W'(cnt_d);
    end
  end

  always_comb begin
    sts_o.full       = cnt_q >= CNT_W'(CAPACITY);
    sts_o.empty      = cnt_q == '0;
    sts_o.present    = present_q[h_q];
    sts_o.pos_bad    = !present_q[h_q] || (CNT_W'(pos_rdata) >= cnt_q);
    sts_o.i_zero     = i_q == '0;
    sts_o.i_last     = i_ext == cnt_m1;
    sts_o.left_in    = left_x < EXT_W'(cnt_q);
    sts_o.right_in   = right_x < EXT_W'(cnt_q);
    sts_o.rd_prec_mv = prec(max_first_q, rd_key, mv_key_q);
    sts_o.right_best = prec(max_first_q, rd_key, best_key);
    sts_o.best_left  = best_left_q;
    sts_o.moved      = moved_q;
  end

  `IHPQ_NEVER(a_cnt_bound, cnt_q > CNT_W'(CAPACITY), "entry count above capacity")
  `IHPQ_ASSERT(a_fin_in_range, cmd_i.fin_write |-> i_ext < cnt_q, "final write beyond last slot")
  `IHPQ_ASSERT(a_taken_absent, cmd_i.take_first |=> !present_q[$past(rd_h)],
               "removed handle still marked present")

endmodule

>>> hdl/ihpq_ctrl.sv
// heap controller: sequences lookup, take-out and sift steps for each beat
`include "indexed_heap_priority_queue_top_macros.svh"
module ihpq_ctrl import ihpq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic [OP_W-1:0] op_i,
  input  sts_t            sts_i,
  output logic            busy,
  output cmd_t            cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_INS  = 14'b00000000000010,
    S_POP  = 14'b00000000000100,
    S_LOOK = 14'b00000000001000,
    S_CHK  = 14'b00000000010000,
    S_TRD  = 14'b00000000100000,
    S_TRL  = 14'b00000001000000,
    S_TML  = 14'b00000010000000,
    S_UCHK = 14'b00000100000000,
    S_UCMP = 14'b00001000000000,
    S_DL   = 14'b00010000000000,
    S_DR   = 14'b00100000000000,
    S_DC   = 14'b01000000000000,
    S_FIN  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  op_e    op_q;
  logic   right_q, right_d;
  logic [4:0] i_src;

  always_comb begin
    state_d      = state_q;
    right_d      = right_q;
    cmd_o        = '0;
    cmd_o.rd_sel = RA_I;
    cmd_o.res    = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch_in = 1'b1;
          case (op_e'(op_i))
            OP_INSERT: state_d = S_INS;
            OP_POP:    state_d = S_POP;
            default:   state_d = S_LOOK;
          endcase
        end
      end
      S_INS: begin
        if (sts_i.full) begin
          cmd_o.done = 1'b1;
          cmd_o.res  = ST_FULL;
          state_d    = S_IDLE;
        end else if (sts_i.present) begin
          cmd_o.done = 1'b1;
          cmd_o.res  = ST_DUP;
          state_d    = S_IDLE;
        end else begin
          cmd_o.ld_ins = 1'b1;
          state_d      = S_UCHK;
        end
      end
      S_POP: begin
        if (sts_i.empty) begin
          cmd_o.done = 1'b1;
          cmd_o.res  = ST_EMPTY;
          state_d    = S_IDLE;
        end else begin
          cmd_o.ld_pop = 1'b1;
          state_d      = S_TRD;
        end
      end
      S_LOOK: state_d = S_CHK;
      S_CHK: begin
        if (sts_i.pos_bad) begin
          cmd_o.done = 1'b1;
          cmd_o.res  = ST_UNKNOWN;
          state_d    = S_IDLE;
        end else if (op_q == OP_REMOVE) begin
          cmd_o.ld_pos = 1'b1;
          state_d      = S_TRD;
        end else begin
          cmd_o.ld_pos   = 1'b1;
          cmd_o.ld_rekey = 1'b1;
          state_d        = S_UCHK;
        end
      end
      S_TRD: state_d = S_TRL;
      S_TRL: begin
        cmd_o.take_first = 1'b1;
        if (sts_i.i_last) begin
          cmd_o.dec_cnt = 1'b1;
          cmd_o.done    = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.rd_sel = RA_LAST;
          state_d      = S_TML;
        end
      end
      S_TML: begin
        cmd_o.ld_last = 1'b1;
        cmd_o.dec_cnt = 1'b1;
        state_d       = S_UCHK;
      end
      S_UCHK: begin
        if (sts_i.i_zero) begin
          state_d = sts_i.moved ? S_FIN : S_DL;
        end else begin
          cmd_o.rd_sel = RA_PARENT;
          state_d      = S_UCMP;
        end
      end
      S_UCMP: begin
        // equal keys still move up
        if (sts_i.rd_prec_mv) begin
          state_d = sts_i.moved ? S_FIN : S_DL;
        end else begin
          cmd_o.up_move = 1'b1;
          state_d       = S_UCHK;
        end
      end
      S_DL: begin
        if (sts_i.left_in) begin
          cmd_o.rd_sel = RA_LEFT;
          state_d      = S_DR;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DR: begin
        cmd_o.dn_left = 1'b1;
        right_d       = sts_i.right_in;
        if (sts_i.right_in) begin
          cmd_o.rd_sel = RA_RIGHT;
        end
        state_d = S_DC;
      end
      S_DC: begin
        if (right_q && sts_i.right_best) begin
          cmd_o.dn_move  = 1'b1;
          cmd_o.dn_right = 1'b1;
          state_d        = S_DL;
        end else if (sts_i.best_left) begin
          cmd_o.dn_move = 1'b1;
          state_d       = S_DL;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin_write = 1'b1;
        cmd_o.done      = 1'b1;
        state_d         = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      right_q <= 1'b0;
    end else begin
      state_q <= state_d;
      right_q <= right_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_o.latch_in) begin
      op_q <= op_e'(op_i);
    end
  end

  assign busy  = state_q != S_IDLE;
  assign i_src = {cmd_o.ld_ins, cmd_o.ld_pop, cmd_o.ld_pos, cmd_o.up_move, cmd_o.dn_move};

  `IHPQ_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted beat did not raise busy")
  `IHPQ_ASSERT(a_done_idle, cmd_o.done |=> state_q == S_IDLE, "result issued mid-operation")
  `IHPQ_ASSERT(a_one_index_src, $onehot0(i_src), "slot index loaded from two sources")

endmodule

>>> tb/testbench.sv
// self-checking testbench for the indexed heap priority queue
module testbench;
  import ihpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = DEF_CAPACITY;
  localparam int LIMIT = 2_000_000;

  typedef struct {
    logic [31:0] okey;
    logic [7:0]  ohandle;
    status_e     st;
    logic [8:0]  occ;
  } res_t;

  typedef struct {
    op_e         op;
    logic [31:0] key;
    logic [7:0]  handle;
    logic        fixed;
    status_e     st;
    logic [8:0]  occ;
  } row_t;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0, cfg_data_i = 0, start = 0;
  logic busy, done_o;
  logic [OP_W-1:0] op_i = '0;
  logic [31:0] key_i = '0;
  logic [7:0] handle_i = '0;
  logic [31:0] out_key_o;
  logic [7:0] out_handle_o;
  logic [STATUS_W-1:0] status_o;
  logic [OCC_W-1:0] occupancy_o;

  indexed_heap_priority_queue_top i_dut (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  // predictor state
  logic [31:0] hk [CAP];
  logic [7:0]  hh [CAP];
  logic [7:0]  pos_of [256];
  bit          live [256];
  int          count;
  bit          max_order;
  res_t        expected_q [$];
  int          errors, beats, results, cycles;
  int          op_seen [4];

  function automatic bit ahead(int a, int b);
    return max_order ? hk[a] > hk[b] : hk[a] < hk[b];
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [31:0] k;
    logic [7:0]  h;
    k = hk[a]; h = hh[a];
    hk[a] = hk[b]; hh[a] = hh[b];
    hk[b] = k; hh[b] = h;
    pos_of[hh[a]] = 8'(a);
    pos_of[hh[b]] = 8'(b);
  endfunction

  function automatic void bubble_up(int i);
    while (i > 0 && !ahead((i - 1) / 2, i)) begin
      swap_slots((i - 1) / 2, i);
      i = (i - 1) / 2;
    end
  endfunction

  function automatic void bubble_down(int i);
    int best;
    forever begin
      best = i;
      if (2 * i + 1 < count && ahead(2 * i + 1, best)) best = 2 * i + 1;
      if (2 * i + 2 < count && ahead(2 * i + 2, best)) best = 2 * i + 2;
      if (best == i) break;
      swap_slots(best, i);
      i = best;
    end
  endfunction

  function automatic void reheap(int i);
    if (i > 0 && !ahead((i - 1) / 2, i)) bubble_up(i);
    else bubble_down(i);
  endfunction

  function automatic void extract(int i, ref res_t r);
    int last;
    last = count - 1;
    r.okey = hk[i];
    r.ohandle = hh[i];
    live[hh[i]] = 0;
    if (i != last) begin
      hk[i] = hk[last];
      hh[i] = hh[last];
      pos_of[hh[i]] = 8'(i);
    end
    count = last;
    if (i < count && count > 1) reheap(i);
  endfunction

  function automatic res_t heap_step(op_e op, logic [31:0] key, logic [7:0] h);
    res_t r;
    r = '{okey: '0, ohandle: '0, st: ST_OK, occ: '0};
    case (op)
      OP_INSERT: begin
        if (count >= CAP) r.st = ST_FULL;
        else if (live[h]) r.st = ST_DUP;
        else begin
          hk[count] = key;
          hh[count] = h;
          pos_of[h] = 8'(count);
          live[h] = 1;
          count++;
          bubble_up(count - 1);
        end
      end
      OP_POP: begin
        if (count == 0) r.st = ST_EMPTY;
        else extract(0, r);
      end
      default: begin
        if (!live[h] || pos_of[h] >= count) r.st = ST_UNKNOWN;
        else if (op == OP_REMOVE) extract(pos_of[h], r);
        else begin
          hk[pos_of[h]] = key;
          reheap(pos_of[h]);
        end
      end
    endcase
    r.occ = count[8:0];
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, results);
  endtask

  // result checker
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni) begin
      cycles++;
      if (done_o) begin
        results++;
        if (expected_q.size() == 0) begin
          report("unexpected result beat", 32'd1, 32'd0);
        end else begin
          e = expected_q.pop_front();
          if (out_key_o !== e.okey) report("out_key", out_key_o, e.okey);
          if (out_handle_o !== e.ohandle)
            report("out_handle", 32'(out_handle_o), 32'(e.ohandle));
          if (status_o !== e.st) report("status", 32'(status_o), 32'(e.st));
          if (occupancy_o !== e.occ) report("occupancy", 32'(occupancy_o), 32'(e.occ));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("timeout");
      $display("Some tests failed");
      $finish;
    end
  end

  // one command beat; typed-in status and occupancy override the predictor when fixed
  task automatic send(row_t r);
    res_t e;
    e = heap_step(r.op, r.key, r.handle);
    if (r.fixed) begin
      e.st = r.st;
      e.occ = r.occ;
    end
    op_seen[r.op]++;
    @(negedge clk_i);
    start <= 1;
    op_i <= r.op;
    key_i <= r.key;
    handle_i <= r.handle;
    do @(posedge clk_i); while (busy);
    expected_q.insert(expected_q.size(), e);
    beats++;
  endtask

  task automatic pause_idle(int n);
    @(negedge clk_i);
    start <= 0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    pause_idle(0);
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic set_order(bit v);
    drain();
    cfg_we_i <= 1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    max_order = v;
  endtask

  // random command mostly aimed at live handles
  function automatic row_t rand_row(int fill_bias);
    row_t r;
    int pick;
    r.fixed = 0; r.st = ST_OK; r.occ = '0;
    pick = $urandom_range(99);
    r.key = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(40);
    if ($urandom_range(9) == 0) r.key = $urandom_range(1) ? 32'hffff_ffff : 32'h0;
    r.handle = 8'($urandom());
    if (pick < fill_bias) r.op = OP_INSERT;
    else if (pick < fill_bias + 15) r.op = OP_POP;
    else if (pick < fill_bias + 30) r.op = OP_REMOVE;
    else r.op = OP_REKEY;
    if (r.op != OP_INSERT && count > 0 && $urandom_range(9) != 0)
      r.handle = hh[$urandom_range(count - 1)];
    return r;
  endfunction

  row_t dir [$];
  row_t rr;
  int burst;

  initial begin
    count = 0; max_order = 0; errors = 0; beats = 0; results = 0; cycles = 0;
    foreach (live[i]) live[i] = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1;

    dir = '{
      '{OP_POP,    32'h0,         8'h00, 1, ST_EMPTY,   9'd0},
      '{OP_REMOVE, 32'h0,         8'h05, 1, ST_UNKNOWN, 9'd0},
      '{OP_REKEY,  32'h1,         8'hff, 1, ST_UNKNOWN, 9'd0},
      '{OP_INSERT, 32'hffff_ffff, 8'hff, 1, ST_OK,      9'd1},
      '{OP_INSERT, 32'h0,         8'h00, 1, ST_OK,      9'd2},
      '{OP_INSERT, 32'h7,         8'h00, 1, ST_DUP,     9'd2},
      '{OP_INSERT, 32'h7,         8'haa, 0, ST_OK,      9'd0},
      '{OP_INSERT, 32'h7,         8'h55, 0, ST_OK,      9'd0},
      '{OP_INSERT, 32'h3,         8'h11, 0, ST_OK,      9'd0},
      '{OP_REKEY,  32'h8000_0000, 8'h00, 0, ST_OK,      9'd0},
      '{OP_REKEY,  32'h0,         8'hff, 0, ST_OK,      9'd0},
      '{OP_REMOVE, 32'h0,         8'h55, 0, ST_OK,      9'd0},
      '{OP_REMOVE, 32'h0,         8'h77, 1, ST_UNKNOWN, 9'd4},
      '{OP_POP,    32'h0,         8'h00, 0, ST_OK,      9'd0},
      '{OP_POP,    32'h0,         8'h00, 0, ST_OK,      9'd0},
      '{OP_REMOVE, 32'h0,         8'h00, 0, ST_OK,      9'd0},
      '{OP_POP,    32'h0,         8'h00, 0, ST_OK,      9'd0},
      '{OP_POP,    32'h0,         8'h00, 1, ST_EMPTY,   9'd0}
    };
    foreach (dir[i]) send(dir[i]);

    // fill to capacity, hit full, then drain by pops
    for (int h = 0; h < CAP; h++) begin
      rr = '{OP_INSERT, $urandom(), h[7:0], 0, ST_OK, '0};
      send(rr);
    end
    rr = '{OP_INSERT, 32'h5, 8'h00, 1, ST_FULL, 9'd256};
    send(rr);
    for (int k = 0; k < CAP; k++) begin
      rr = '{OP_POP, 32'h0, 8'h00, 0, ST_OK, '0};
      send(rr);
    end

    for (int phase = 0; phase < 4; phase++) begin
      set_order(phase % 2 == 0);
      for (int n = 0; n < 300; ) begin
        burst = $urandom_range(1, 20);
        repeat (burst) begin
          rr = rand_row(count < 20 ? 55 : (count > 200 ? 10 : 30));
          send(rr);
          n++;
        end
        if ($urandom_range(2) != 0) pause_idle($urandom_range(1, 30));
      end
    end
    set_order(0);
    drain();

    $display("ran %0d beats, %0d results; inserts %0d pops %0d removes %0d rekeys %0d",
             beats, results, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("both orderings, full and empty queue, duplicate and unknown handles");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
